### rtl/core/rconv_pkg.sv
`default_nettype none

package rconv_pkg;

    // Width of one digit value and of a base register
    localparam int unsigned DIGIT_W = 6;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned OCHAR_W = 7;

    localparam int unsigned VALUE_BITS_DEF = 32;

    localparam logic [DIGIT_W-1:0] BASE_RESET = 6'd10;
    localparam logic [DIGIT_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [DIGIT_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;

    // Configuration register indexes
    localparam logic CFG_SRC_BASE = 1'b0;
    localparam logic CFG_TGT_BASE = 1'b1;

    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ   = 8'h7A;

    // Status of the bit-serial divider
    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] rem;
    } t_div_status;

    // Keep a base register within 2..36
    function automatic logic [DIGIT_W-1:0] clamp_base(input logic [DIGIT_W-1:0] b);
        logic [DIGIT_W-1:0] r;
        if (b < BASE_MIN) begin
            r = BASE_MIN;
        end else if (b > BASE_MAX) begin
            r = BASE_MAX;
        end else begin
            r = b;
        end
        return r;
    endfunction

    // Map an ASCII digit to its value; anything unrecognized is zero
    function automatic logic [DIGIT_W-1:0] char_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] t;
        t = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            t = c - CH_ZERO;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            t = c - CH_UA + CHAR_W'(DEC_DIGITS);
        end else if (c >= CH_LA && c <= CH_LZ) begin
            t = c - CH_LA + CHAR_W'(DEC_DIGITS);
        end
        return t[DIGIT_W-1:0];
    endfunction

    // Map a digit value 0..35 to uppercase ASCII
    function automatic logic [OCHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] t;
        if (d < DEC_DIGITS) begin
            t = CH_ZERO + CHAR_W'(d);
        end else begin
            t = CH_UA + CHAR_W'(d) - CHAR_W'(DEC_DIGITS);
        end
        return t[OCHAR_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/radix_converter_unit.sv
// Channel   Dir  Payload                               Handshake
// s_axis    in   tdata[7:0] digit_char, tlast last     tvalid/tready
// m_axis    out  tdata[6:0] out_char, tlast last_digit tvalid/tready
// cfg       in   idx 0 source_base, 1 target_base      we only
//
// Each character is captured, then added in with one multiply-add.
// On the last character the value is divided bit-serially by the target
// base once per result digit, and the digits then stream out one per cycle,
// while the output is ready, from the remainder store, most significant first.
// Characters of the next number are taken while digits still stream out.
// Synchronous active-low reset clears the accumulator, counts and bases (10).
`default_nettype none

module radix_converter_unit #(
    parameter int unsigned VALUE_BITS = rconv_pkg::VALUE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_idx,
    input  wire logic [rconv_pkg::DIGIT_W-1:0]  i_cfg_data,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [7:0]                     i_s_axis_tdata, // [7:0] digit_char
    input  wire logic                           i_s_axis_tlast, // last_char
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    output logic [7:0]                          o_m_axis_tdata, // [6:0] out_char
    output logic                                o_m_axis_tlast  // last_digit
);
    import rconv_pkg::*;

    localparam int unsigned AW = $clog2(VALUE_BITS);
    localparam int unsigned CW = $clog2(VALUE_BITS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAC  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [DIGIT_W-1:0]    r_src_base;
    logic [DIGIT_W-1:0]    r_tgt_base;
    logic [VALUE_BITS-1:0] r_acc;
    logic [DIGIT_W-1:0]    r_digit;
    logic                  r_last;
    logic [CW-1:0]         r_count;

    logic                  w_accept;
    logic [VALUE_BITS+DIGIT_W-1:0] w_prod;
    logic [VALUE_BITS-1:0] w_mac;
    logic                  w_emit_busy;
    logic                  w_first_start;
    logic                  w_more;
    logic                  w_div_start;
    logic                  w_store_we;
    logic                  w_emit_start;
    logic [VALUE_BITS-1:0] w_dividend;
    logic [VALUE_BITS-1:0] w_quo;
    t_div_status           w_div;

    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);

    // Multiply-add with wrap to VALUE_BITS
    assign w_prod = r_acc * clamp_base(r_src_base);
    assign w_mac  = w_prod[VALUE_BITS-1:0] + {{(VALUE_BITS-DIGIT_W){1'b0}}, r_digit};

    // Division sequencing
    assign w_first_start = (r_state == S_WAIT) && !w_emit_busy;
    assign w_store_we    = (r_state == S_DIV) && w_div.done;
    assign w_more        = (w_quo != '0) && (r_count != CW'(VALUE_BITS - 1));
    assign w_div_start   = w_first_start || (w_store_we && w_more);
    assign w_emit_start  = w_store_we && !w_more;
    assign w_dividend    = (r_state == S_WAIT) ? r_acc : w_quo;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_base <= BASE_RESET;
            r_tgt_base <= BASE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SRC_BASE: r_src_base <= i_cfg_data;
                CFG_TGT_BASE: r_tgt_base <= i_cfg_data;
                default:      r_src_base <= r_src_base;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_MAC;
            S_MAC:  n_state = r_last ? S_WAIT : S_IDLE;
            S_WAIT: if (!w_emit_busy) n_state = S_DIV;
            S_DIV:  if (w_emit_start) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State, accumulator and digit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MAC) begin
                r_acc <= w_mac;
            end else if (w_first_start) begin
                r_acc <= '0;
            end
            if (w_first_start || w_emit_start) begin
                r_count <= '0;
            end else if (w_store_we) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Capture the character value on accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_digit <= char_value(i_s_axis_tdata);
            r_last  <= i_s_axis_tlast;
        end
    end

    rconv_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (clamp_base(r_tgt_base)),
        .o_quotient (w_quo),
        .o_status   (w_div)
    );

    rconv_emitter #(
        .VALUE_BITS (VALUE_BITS)
    ) u_emitter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr_en         (w_store_we),
        .i_wr_addr       (r_count[AW-1:0]),
        .i_wr_data       (w_div.rem),
        .i_start         (w_emit_start),
        .i_count         (r_count + 1'b1),
        .o_busy          (w_emit_busy),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

`ifndef SYNTH
    // No digit is presented while a conversion writes the store
    a_no_out_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !o_m_axis_tvalid)
        else $error("result digit shown during division");

    // Divider only finishes while a conversion runs
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_DIV))
        else $error("divider done outside division");

    // Digit count stays within the store
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CW'(VALUE_BITS))
        else $error("digit count out of range");

    // Input is refused until a final character's digits are all stored
    a_wait_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MAC) && r_last) |=> !o_s_axis_tready)
        else $error("input taken before conversion");
`endif

endmodule

`default_nettype wire

### rtl/core/rconv_divider.sv
`default_nettype none

module rconv_divider #(
    parameter int unsigned VALUE_BITS = rconv_pkg::VALUE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [VALUE_BITS-1:0]          i_dividend,
    input  wire logic [rconv_pkg::DIGIT_W-1:0]  i_divisor,
    output logic [VALUE_BITS-1:0]               o_quotient,
    output rconv_pkg::t_div_status              o_status
);
    import rconv_pkg::*;

    localparam int unsigned CW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] r_quo;
    logic [DIGIT_W-1:0]    r_rem;
    logic [DIGIT_W-1:0]    r_div;
    logic [CW-1:0]         r_cnt;
    logic                  r_done;

    logic [DIGIT_W:0]      w_trial;
    logic                  w_ge;
    logic [DIGIT_W:0]      w_diff;

    // One restoring step: bring down the next dividend bit
    assign w_trial = {r_rem, r_quo[VALUE_BITS-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    // Control: step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CW'(VALUE_BITS);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Datapath: shift quotient bits in, keep the partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[VALUE_BITS-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIGIT_W-1:0] : w_trial[DIGIT_W-1:0];
        end
    end

    assign o_quotient    = r_quo;
    assign o_status.done = r_done;
    assign o_status.rem  = r_rem;

endmodule

`default_nettype wire

### rtl/core/rconv_emitter.sv
`default_nettype none

module rconv_emitter #(
    parameter int unsigned VALUE_BITS = rconv_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // remainder write port
    input  wire logic                                i_wr_en,
    input  wire logic [$clog2(VALUE_BITS)-1:0]       i_wr_addr,
    input  wire logic [rconv_pkg::DIGIT_W-1:0]       i_wr_data,
    // start readout of the given number of digits
    input  wire logic                                i_start,
    input  wire logic [$clog2(VALUE_BITS+1)-1:0]     i_count,
    output logic                                     o_busy,
    // result stream
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    output logic [7:0]                               o_m_axis_tdata, // [6:0] out_char
    output logic                                     o_m_axis_tlast  // last_digit
);
    import rconv_pkg::*;

    localparam int unsigned AW = $clog2(VALUE_BITS);
    localparam int unsigned CW = $clog2(VALUE_BITS + 1);

    logic [DIGIT_W-1:0] r_mem [VALUE_BITS];
    logic [DIGIT_W-1:0] r_rd_data;
    logic [CW-1:0]      r_left;
    logic               r_ovalid;
    logic               r_olast;

    logic               w_rd_en;
    logic [CW-1:0]      w_left_m1;

    // Read the most significant remaining digit once the output slot frees up
    assign w_left_m1 = r_left - 1'b1;
    assign w_rd_en   = (r_left != '0) && (!r_ovalid || i_m_axis_tready);

    // Remainder store
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_left_m1[AW-1:0]];
            r_olast   <= (r_left == CW'(1));
        end
    end

    // Readout control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_start) begin
                r_left <= i_count;
            end else if (w_rd_en) begin
                r_left <= w_left_m1;
            end
            if (w_rd_en) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_busy          = (r_left != '0) || r_ovalid;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, digit_char(r_rd_data)};
    assign o_m_axis_tlast  = r_olast;

endmodule

`default_nettype wire
